[rtl/okvt_pkg.sv]
`timescale 1ns / 1ps

package okvt_pkg;

  // Table geometry
  localparam int CAPACITY   = 16;
  localparam int KEY_BYTES  = 8;
  localparam int VALUE_BITS = 32;

  // Fixed field widths of the ports
  localparam int KIND_W      = 3;
  localparam int KEY_W       = 64;
  localparam int VAL_IN_W    = 32;
  localparam int INDEX_W     = 4;
  localparam int COUNT_OUT_W = 5;

  // Entry position and fill count widths
  localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EXISTS = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_KEY_AT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_COUNT  = 3'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch an accepted operation
    logic lookup;   // register the key search
    logic exec;     // update the table and load the result
  } okvt_cmd_t;

endpackage

[rtl/ordered_key_value_table_core.sv]
// The input transfer is captured, the key search (compare against every
//   live entry) is registered, then the table is updated and the result
//   loaded; a new operation is accepted in the execute step of the last.
// A pending result stalls the update stage until it is taken.
// Reset (rst_ni low, asynchronous): table empties, no result pending;
//   no clearing pass, the block accepts right after reset.
`timescale 1ns / 1ps

module ordered_key_value_table_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // operation channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [okvt_pkg::KIND_W-1:0]           kind_i,
  input  logic [okvt_pkg::KEY_W-1:0]            key_i,
  input  logic [okvt_pkg::VAL_IN_W-1:0]         value_i,
  input  logic [okvt_pkg::INDEX_W-1:0]          index_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  ok_o,
  output logic [okvt_pkg::VAL_IN_W-1:0]         value_out_o,
  output logic [okvt_pkg::KEY_W-1:0]            key_out_o,
  output logic [okvt_pkg::COUNT_OUT_W-1:0]      entry_count_o
);

  // Commands from the sequencer: capture the transfer, register the
  // search, then apply the update and load the result register.
  okvt_pkg::okvt_cmd_t cmd;

  // Sequencer: idle -> lookup -> execute. A new transfer is taken in the
  // execute cycle when the result slot frees up, so operations overlap
  // by one stage and the table is already updated when the next search runs.
  okvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Table storage, parallel key compare, shift-down on delete and the
  // result register.
  okvt_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (kind_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .index_i       (index_i),
    .ok_o          (ok_o),
    .value_out_o   (value_out_o),
    .key_out_o     (key_out_o),
    .entry_count_o (entry_count_o)
  );

endmodule

[rtl/okvt_ctrl.sv]
`timescale 1ns / 1ps

module okvt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output okvt_pkg::okvt_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_EXEC   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) || ((state_q == ST_EXEC) && out_free));
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.capture = accept;
  assign cmd_o.lookup  = (state_q == ST_LOOKUP);
  assign cmd_o.exec    = (state_q == ST_EXEC) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = accept ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_lookup_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |=> (state_q == ST_EXEC))
    else $error("lookup not followed by execute");

  a_exec_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_q)
    else $error("executed operation left no result");

  a_exec_waits_for_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EXEC) && out_valid_q && out_stall_i) |=> (state_q == ST_EXEC))
    else $error("execute left while result slot was occupied");
`endif

endmodule

[rtl/okvt_datapath.sv]
`timescale 1ns / 1ps

module okvt_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  okvt_pkg::okvt_cmd_t                   cmd_i,
  input  logic [okvt_pkg::KIND_W-1:0]           kind_i,
  input  logic [okvt_pkg::KEY_W-1:0]            key_i,
  input  logic [okvt_pkg::VAL_IN_W-1:0]         value_i,
  input  logic [okvt_pkg::INDEX_W-1:0]          index_i,
  output logic                                  ok_o,
  output logic [okvt_pkg::VAL_IN_W-1:0]         value_out_o,
  output logic [okvt_pkg::KEY_W-1:0]            key_out_o,
  output logic [okvt_pkg::COUNT_OUT_W-1:0]      entry_count_o
);

  localparam int CAP   = okvt_pkg::CAPACITY;
  localparam int VB    = okvt_pkg::VALUE_BITS;
  localparam int POS_W = okvt_pkg::POS_W;
  localparam int CNT_W = okvt_pkg::CNT_W;
  localparam int KEY_W = okvt_pkg::KEY_W;

  // Table storage and fill count
  logic [KEY_W-1:0] key_store_q [CAP];
  logic [KEY_W-1:0] key_store_d [CAP];
  logic [VB-1:0]    value_store_q [CAP];
  logic [VB-1:0]    value_store_d [CAP];
  logic [CNT_W-1:0] count_q, count_d;

  // Latched operation
  logic [okvt_pkg::KIND_W-1:0]  kind_q;
  logic [KEY_W-1:0]             key_q, key_canon;
  logic [VB-1:0]                value_q;
  logic [okvt_pkg::INDEX_W-1:0] index_q;

  // Search result
  logic [CAP-1:0]   match;
  logic             hit_q, hit_d;
  logic [POS_W-1:0] pos_q, pos_d;

  // Result register
  logic                                  ok_q, ok_d;
  logic [okvt_pkg::VAL_IN_W-1:0]         vout_q, vout_d;
  logic [KEY_W-1:0]                      kout_q, kout_d;
  logic [okvt_pkg::COUNT_OUT_W-1:0]      cnt_out_q;

  // Cut the key at its first zero byte
  always_comb begin
    logic alive;
    alive     = 1'b1;
    key_canon = '0;
    for (int b = 0; b < okvt_pkg::KEY_BYTES; b++) begin
      alive = alive && (key_i[8*b +: 8] != 8'd0);
      if (alive) key_canon[8*b +: 8] = key_i[8*b +: 8];
    end
  end

  // Compare against every live entry; live keys are unique, so OR-encode
  always_comb begin
    pos_d = '0;
    for (int i = 0; i < CAP; i++) begin
      match[i] = (i < int'(count_q)) && (key_store_q[i] == key_q);
      if (match[i]) pos_d = pos_d | POS_W'(i);
    end
    hit_d = |match;
  end

  always_comb begin
    key_store_d   = key_store_q;
    value_store_d = value_store_q;
    count_d       = count_q;
    ok_d          = 1'b0;
    vout_d        = '0;
    kout_d        = '0;
    case (kind_q)
      okvt_pkg::KIND_SET: begin
        if (hit_q) begin
          value_store_d[pos_q] = value_q;
          ok_d                 = 1'b1;
        end else if (count_q < CNT_W'(CAP)) begin
          key_store_d[count_q[POS_W-1:0]]   = key_q;
          value_store_d[count_q[POS_W-1:0]] = value_q;
          count_d                           = count_q + CNT_W'(1);
          ok_d                              = 1'b1;
        end
      end
      okvt_pkg::KIND_GET: begin
        if (hit_q) begin
          ok_d   = 1'b1;
          vout_d = okvt_pkg::VAL_IN_W'(value_store_q[pos_q]);
        end
      end
      okvt_pkg::KIND_EXISTS: begin
        ok_d = hit_q;
      end
      okvt_pkg::KIND_DELETE: begin
        if (hit_q) begin
          // shift everything above the hit down one place
          for (int j = 0; j < CAP - 1; j++) begin
            if (int'(pos_q) <= j) begin
              key_store_d[j]   = key_store_q[j+1];
              value_store_d[j] = value_store_q[j+1];
            end
          end
          count_d = count_q - CNT_W'(1);
          ok_d    = 1'b1;
        end
      end
      okvt_pkg::KIND_KEY_AT: begin
        if (int'(index_q) < int'(count_q)) begin
          ok_d = 1'b1;
          for (int i = 0; i < CAP; i++) begin
            if (int'(index_q) == i) kout_d = key_store_q[i];
          end
        end
      end
      okvt_pkg::KIND_COUNT: begin
        ok_d = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      key_q   <= key_canon;
      value_q <= VB'(value_i);
      index_q <= index_i;
    end
    if (cmd_i.lookup) begin
      hit_q <= hit_d;
      pos_q <= pos_d;
    end
    if (cmd_i.exec) begin
      key_store_q   <= key_store_d;
      value_store_q <= value_store_d;
      ok_q          <= ok_d;
      vout_q        <= vout_d;
      kout_q        <= kout_d;
      cnt_out_q     <= okvt_pkg::COUNT_OUT_W'(count_d);
    end
  end

  assign ok_o          = ok_q;
  assign value_out_o   = vout_q;
  assign key_out_o     = kout_q;
  assign entry_count_o = cnt_out_q;

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> (int'(count_q) <= CAP))
    else $error("entry count beyond capacity");
`endif

endmodule
